@@ hw/rtl/flat_json_pair_extractor_unit_defines.svh @@
// Assertion macros used by the checker file of the pair extractor.
`ifndef FLAT_JSON_PAIR_EXTRACTOR_UNIT_DEFINES_SVH
`define FLAT_JSON_PAIR_EXTRACTOR_UNIT_DEFINES_SVH

// Same-cycle implication, inactive while reset is asserted.
`define FJPE_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fjpe port check failed");

// Next-cycle implication, inactive while reset is asserted.
`define FJPE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fjpe port check failed");

// Condition that must hold in the cycle after a reset cycle.
`define FJPE_ASSERT_AFTER_RESET(lbl, cons) \
    lbl: assert property (@(posedge i_clk) (!i_rst_n) |=> (cons)) \
        else $error("fjpe reset check failed");

`endif

@@ hw/rtl/fjpe_pkg.sv @@
package fjpe_pkg;

    // Length caps on emitted key and value characters.
    localparam int KEY_MAX   = 255;
    localparam int VALUE_MAX = 255;

    localparam int KEY_CNT_W = $clog2(KEY_MAX + 1);
    localparam int VAL_CNT_W = $clog2(VALUE_MAX + 1);

    // Character codes.
    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_COMMA     = 8'h2C;
    localparam logic [7:0] CH_COLON     = 8'h3A;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;

    // Capitals lie strictly between these two codes.
    localparam logic [7:0] CH_UPPER_LO  = 8'd64;
    localparam logic [7:0] CH_UPPER_HI  = 8'd91;
    localparam logic [7:0] CASE_OFFSET  = 8'd32;

    typedef enum logic [1:0] {
        KIND_KEY      = 2'd0,
        KIND_VALUE    = 2'd1,
        KIND_PAIR_END = 2'd2
    } t_char_kind;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       final_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_char;
        t_char_kind char_kind;
        logic       value_quoted;
        logic       run_end;
    } t_out_item;

    // Results of one parse step: a character, a pair-end marker, or both.
    typedef struct packed {
        logic      first_valid;
        logic      second_valid;
        t_out_item first;
        t_out_item second;
    } t_step_res;

endpackage

@@ hw/rtl/fjpe_core.sv @@
module fjpe_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  fjpe_pkg::t_in_item i_item,
    output fjpe_pkg::t_step_res o_res
);
    import fjpe_pkg::*;

    typedef enum logic [4:0] {
        PH_OUT  = 5'b00001,
        PH_KEY  = 5'b00010,
        PH_SEP  = 5'b00100,
        PH_VAL  = 5'b01000,
        PH_SKIP = 5'b10000
    } t_phase;

    t_phase                 r_phase, n_phase;
    logic [KEY_CNT_W-1:0]   r_key_count, n_key_count;
    logic [VAL_CNT_W-1:0]   r_value_count, n_value_count;
    logic                   r_string_mode, n_string_mode;
    logic                   r_prev_backslash, n_prev_backslash;
    logic                   r_halted, n_halted;

    logic [7:0]             b;
    logic                   fin_eff;

    logic                   vb_sm;
    logic                   vb_pb;
    logic [VAL_CNT_W-1:0]   vb_vc;
    logic                   vb_quote_end;
    logic                   vb_term;
    logic                   vb_run;

    logic                   c_v;
    logic [7:0]             c_char;
    t_char_kind             c_kind;
    logic                   c_q;
    logic                   close_req;
    logic                   m_v;
    t_out_item              marker;

    assign b       = i_item.text_byte;
    assign fin_eff = i_item.final_byte | (b == CH_NUL);

    // Value byte context: the first value byte comes from the separator phase
    // with fresh value state.
    always_comb begin
        vb_sm        = (r_phase == PH_SEP) ? 1'b0 : r_string_mode;
        vb_pb        = (r_phase == PH_SEP) ? 1'b0 : r_prev_backslash;
        vb_vc        = (r_phase == PH_SEP) ? '0 : r_value_count;
        vb_quote_end = vb_sm && (b == CH_QUOTE) && !vb_pb;
        if (vb_sm) begin
            vb_term = vb_quote_end || (b == CH_RBRACE);
        end else begin
            vb_term = (b == CH_SPACE) || (b == CH_NEWLINE) ||
                      (b == CH_RBRACE) || (b == CH_COMMA);
        end
    end

    always_comb begin
        n_phase          = r_phase;
        n_key_count      = r_key_count;
        n_value_count    = r_value_count;
        n_string_mode    = r_string_mode;
        n_prev_backslash = r_prev_backslash;
        n_halted         = r_halted;
        c_v              = 1'b0;
        c_char           = b;
        c_kind           = KIND_KEY;
        c_q              = 1'b0;
        close_req        = 1'b0;
        vb_run           = 1'b0;

        if (!r_halted) begin
            if (b != CH_NUL) begin
                unique case (r_phase)
                    PH_OUT: begin
                        if (b == CH_QUOTE) begin
                            n_phase          = PH_KEY;
                            n_key_count      = '0;
                            n_value_count    = '0;
                            n_string_mode    = 1'b0;
                            n_prev_backslash = 1'b0;
                        end
                    end
                    PH_KEY: begin
                        if (b == CH_QUOTE) begin
                            n_phase = PH_SEP;
                        end else if (r_key_count < KEY_CNT_W'(KEY_MAX)) begin
                            c_v = 1'b1;
                            if (b > CH_UPPER_LO && b < CH_UPPER_HI) begin
                                c_char = b + CASE_OFFSET;
                            end
                            n_key_count = r_key_count + 1'b1;
                        end
                    end
                    PH_SEP: begin
                        if (b != CH_COMMA && b != CH_SPACE && b != CH_COLON) begin
                            n_value_count    = '0;
                            n_prev_backslash = 1'b0;
                            n_phase          = PH_VAL;
                            if (b == CH_QUOTE) begin
                                n_string_mode = 1'b1;
                            end else begin
                                n_string_mode = 1'b0;
                                vb_run        = 1'b1;
                            end
                        end
                    end
                    PH_VAL: begin
                        vb_run = 1'b1;
                    end
                    PH_SKIP: begin
                        n_phase = PH_OUT;
                    end
                    default: begin
                        n_phase = PH_OUT;
                    end
                endcase

                if (vb_run) begin
                    if (vb_term) begin
                        close_req = 1'b1;
                        n_phase   = vb_quote_end ? PH_SKIP : PH_OUT;
                    end else begin
                        if (vb_vc < VAL_CNT_W'(VALUE_MAX)) begin
                            c_v           = 1'b1;
                            c_kind        = KIND_VALUE;
                            c_q           = vb_sm;
                            n_value_count = vb_vc + 1'b1;
                        end
                        n_prev_backslash = (b == CH_BACKSLASH);
                    end
                end
            end

            // End of document: close a pair still open, then stop.
            if (fin_eff) begin
                if (n_phase == PH_KEY || n_phase == PH_SEP || n_phase == PH_VAL) begin
                    close_req = 1'b1;
                end
                n_phase  = PH_OUT;
                n_halted = 1'b1;
            end
        end
    end

    assign m_v = close_req && (n_key_count != '0);

    always_comb begin
        marker.out_char     = 8'h00;
        marker.char_kind    = KIND_PAIR_END;
        marker.value_quoted = n_string_mode;
        marker.run_end      = 1'b1;

        o_res.first_valid  = c_v | m_v;
        o_res.second_valid = c_v & m_v;
        o_res.second       = marker;
        if (c_v) begin
            o_res.first.out_char     = c_char;
            o_res.first.char_kind    = c_kind;
            o_res.first.value_quoted = c_q;
            o_res.first.run_end      = !m_v;
        end else begin
            o_res.first = marker;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= PH_OUT;
            r_key_count      <= '0;
            r_value_count    <= '0;
            r_string_mode    <= 1'b0;
            r_prev_backslash <= 1'b0;
            r_halted         <= 1'b0;
        end else if (i_fire) begin
            r_phase          <= n_phase;
            r_key_count      <= n_key_count;
            r_value_count    <= n_value_count;
            r_string_mode    <= n_string_mode;
            r_prev_backslash <= n_prev_backslash;
            r_halted         <= n_halted;
        end
    end

endmodule

@@ hw/rtl/fjpe_out_queue.sv @@
module fjpe_out_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  fjpe_pkg::t_step_res i_res,
    input  logic                i_out_ready,
    output logic                o_room,
    output logic                o_out_valid,
    output fjpe_pkg::t_out_item o_out_item
);
    import fjpe_pkg::*;

    logic [1:0] r_cnt, n_cnt;
    t_out_item  r_head, n_head;
    t_out_item  r_next, n_next;

    logic       pop;
    logic [1:0] keep;
    logic [1:0] need;
    t_out_item  head_after_pop;

    assign pop    = i_out_ready && (r_cnt != 2'd0);
    assign keep   = r_cnt - {1'b0, pop};
    assign need   = {1'b0, i_res.first_valid} + {1'b0, i_res.second_valid};
    assign o_room = ({1'b0, keep} + {1'b0, need}) <= 3'd2;

    assign head_after_pop = pop ? r_next : r_head;

    always_comb begin
        n_cnt  = keep;
        n_head = head_after_pop;
        n_next = r_next;
        if (i_push) begin
            n_cnt = keep + need;
            unique case (keep)
                2'd0: begin
                    n_head = i_res.first;
                    n_next = i_res.second;
                end
                2'd1: begin
                    n_next = i_res.first;
                end
                default: begin
                    // full: push only comes with no results
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head <= n_head;
        r_next <= n_next;
    end

    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out_item  = r_head;

endmodule

@@ hw/rtl/flat_json_pair_extractor_unit.sv @@
// Flat key/value pair extractor. Text enters one byte per item; key characters
// (capitals lowercased) and value characters leave one per result item, and a
// pair-end marker follows each value whose key was not empty. An input item is
// taken every cycle while the two-entry result queue has room for what the
// byte produces; a byte causes at most two results (a character, then a
// marker). Since the result port moves one item per cycle while the receiver
// is ready, a stream runs at one byte per cycle when each byte causes at most
// one result and the output does not stall; otherwise the input waits on the
// queue. An accepted byte waits in the input register; the parse step then
// feeds the queue. A NUL byte or a byte flagged final closes any open pair and
// halts the parser; later bytes are taken and produce nothing until reset.
module flat_json_pair_extractor_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  fjpe_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output fjpe_pkg::t_out_item o_out_item
);
    import fjpe_pkg::*;

    // Input register: hold the item until the parse step can retire it.
    logic      r_in_valid;
    t_in_item  r_in;

    t_step_res step_res;
    logic      room;
    logic      fire;

    // Retire the held byte once the queue can take all of its results.
    assign fire       = r_in_valid && room;
    assign o_in_ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_item;
        end
    end

    // Parse step: phase state plus the per-byte decision.
    fjpe_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_item  (r_in),
        .o_res   (step_res)
    );

    // Result queue: separate the parser from output stalls.
    fjpe_out_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (fire),
        .i_res       (step_res),
        .i_out_ready (i_out_ready),
        .o_room      (room),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

@@ hw/rtl/fjpe_checker.sv @@
`include "flat_json_pair_extractor_unit_defines.svh"

module fjpe_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input fjpe_pkg::t_out_item o_out_item
);
    import fjpe_pkg::*;

    logic out_stall;
    logic marker_out;
    logic marker_ok;
    logic key_out;

    assign out_stall  = o_out_valid && !i_out_ready;
    assign marker_out = o_out_valid && (o_out_item.char_kind == KIND_PAIR_END);
    assign marker_ok  = (o_out_item.out_char == 8'h00) && o_out_item.run_end;
    assign key_out    = o_out_valid && (o_out_item.char_kind == KIND_KEY);

    `FJPE_ASSERT_AFTER_RESET(a_no_result_after_reset, !o_out_valid)
    `FJPE_ASSERT_NEXT(a_out_hold, out_stall, o_out_valid && $stable(o_out_item))
    `FJPE_ASSERT_IMPLY(a_marker_form, marker_out, marker_ok)
    `FJPE_ASSERT_IMPLY(a_key_unquoted, key_out, !o_out_item.value_quoted)

endmodule

bind flat_json_pair_extractor_unit fjpe_checker u_fjpe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

@@ tb/testbench.sv @@
module testbench;
    import fjpe_pkg::*;

    // Parser phases as the predictor tracks them.
    typedef enum logic [2:0] {
        PH_OUTSIDE,
        PH_KEY,
        PH_SEPARATOR,
        PH_VALUE,
        PH_SKIP_ONE
    } t_parse_phase;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_LIMIT = 5000;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_item  in_item   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_item;

    // Idle percentages for the two sides, changed between test phases.
    int gap_pct     = 0;
    int stall_pct   = 0;
    int bytes_sent  = 0;
    int error_count = 0;
    int cycle_count = 0;

    // Predictor state: a private copy of the parser.
    t_parse_phase parse_phase     = PH_OUTSIDE;
    int           key_len         = 0;
    int           value_len       = 0;
    logic         quoted_value    = 1'b0;
    logic         after_backslash = 1'b0;
    logic         parser_halted   = 1'b0;

    // Results of the byte being predicted, and results still to arrive.
    t_out_item byte_results[$];
    t_out_item awaited_chars[$];
    t_out_item expected_head;

    flat_json_pair_extractor_unit dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item (out_item)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Bound the run; a hang anywhere ends here.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= 10) begin
            $display("%s", msg);
        end
    endtask

    function automatic t_out_item make_result(input logic [7:0] ch, input t_char_kind kind,
                                              input logic q);
        t_out_item r;
        r.out_char     = ch;
        r.char_kind    = kind;
        r.value_quoted = q;
        r.run_end      = 1'b0;
        return r;
    endfunction

    // Emit the pair-end marker, except for a pair whose key was empty.
    task automatic close_pair;
        if (key_len > 0) begin
            byte_results.push_back(make_result(CH_NUL, KIND_PAIR_END, quoted_value));
        end
    endtask

    // One byte inside a value: either it ends the value or it is a value char.
    task automatic take_value_char(input logic [7:0] b);
        if (!quoted_value && (b == CH_SPACE || b == CH_NEWLINE ||
                              b == CH_RBRACE || b == CH_COMMA)) begin
            close_pair();
            parse_phase = PH_OUTSIDE;
        end else if (quoted_value && b == CH_QUOTE && !after_backslash) begin
            close_pair();
            parse_phase = PH_SKIP_ONE;
        end else if (quoted_value && b == CH_RBRACE) begin
            close_pair();
            parse_phase = PH_OUTSIDE;
        end else begin
            // Past the cap the char is dropped but still arms the escape.
            if (value_len < VALUE_MAX) begin
                byte_results.push_back(make_result(b, KIND_VALUE, quoted_value));
                value_len++;
            end
            after_backslash = (b == CH_BACKSLASH);
        end
    endtask

    // Advance the predictor by one accepted byte and queue what it causes.
    task automatic parse_text_byte(input t_in_item it);
        logic [7:0] b;
        logic       stop;
        b    = it.text_byte;
        stop = it.final_byte;
        byte_results.delete();
        if (parser_halted) begin
            return;
        end
        if (b == CH_NUL) begin
            stop = 1'b1;
        end else begin
            case (parse_phase)
                PH_OUTSIDE: begin
                    if (b == CH_QUOTE) begin
                        parse_phase     = PH_KEY;
                        key_len         = 0;
                        value_len       = 0;
                        quoted_value    = 1'b0;
                        after_backslash = 1'b0;
                    end
                end
                PH_KEY: begin
                    if (b == CH_QUOTE) begin
                        parse_phase = PH_SEPARATOR;
                    end else if (key_len < KEY_MAX) begin
                        // Fold ASCII capitals only; high bytes pass unchanged.
                        byte_results.push_back(make_result(
                            (b > CH_UPPER_LO && b < CH_UPPER_HI) ? b + CASE_OFFSET : b,
                            KIND_KEY, 1'b0));
                        key_len++;
                    end
                end
                PH_SEPARATOR: begin
                    if (b != CH_COMMA && b != CH_SPACE && b != CH_COLON) begin
                        value_len       = 0;
                        after_backslash = 1'b0;
                        parse_phase     = PH_VALUE;
                        if (b == CH_QUOTE) begin
                            quoted_value = 1'b1;
                        end else begin
                            quoted_value = 1'b0;
                            take_value_char(b);
                        end
                    end
                end
                PH_VALUE: begin
                    take_value_char(b);
                end
                default: begin
                    parse_phase = PH_OUTSIDE;
                end
            endcase
        end
        if (stop) begin
            if (parse_phase inside {PH_KEY, PH_SEPARATOR, PH_VALUE}) begin
                close_pair();
            end
            parse_phase   = PH_OUTSIDE;
            parser_halted = 1'b1;
        end
        if (byte_results.size() > 0) begin
            byte_results[byte_results.size() - 1].run_end = 1'b1;
            foreach (byte_results[i]) begin
                awaited_chars.push_back(byte_results[i]);
            end
        end
    endtask

    // Offer one item, idling first at random; return once it is accepted.
    task automatic send_byte(input logic [7:0] b, input logic fin = 1'b0);
        t_in_item item;
        item.text_byte  = b;
        item.final_byte = fin;
        if ($urandom_range(99) < gap_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < gap_pct);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        do @(posedge clk); while (!in_ready);
        bytes_sent++;
        parse_text_byte(item);
    endtask

    // Random nonzero byte other than the four given.
    function automatic logic [7:0] pick_char(input logic [7:0] a, input logic [7:0] b,
                                             input logic [7:0] c, input logic [7:0] d);
        logic [7:0] ch;
        do ch = 8'($urandom_range(255, 1)); while (ch == a || ch == b || ch == c || ch == d);
        return ch;
    endfunction

    // Mostly short fields, now and then a long one near or beyond the caps.
    function automatic int random_field_len();
        return ($urandom_range(79) == 0) ? $urandom_range(270, 250) : $urandom_range(6);
    endfunction

    // Send one well-formed pair with random content.
    task automatic send_pair(input int klen, input int vlen, input logic quoted);
        logic [7:0] ch;
        logic       last_bs;
        last_bs = 1'b0;
        send_byte(CH_QUOTE);
        repeat (klen) begin
            if ($urandom_range(2) == 0) ch = 8'($urandom_range(90, 65));
            else ch = pick_char(CH_QUOTE, CH_QUOTE, CH_QUOTE, CH_QUOTE);
            send_byte(ch);
        end
        send_byte(CH_QUOTE);
        repeat ($urandom_range(3)) begin
            case ($urandom_range(2))
                0:       send_byte(CH_COMMA);
                1:       send_byte(CH_SPACE);
                default: send_byte(CH_COLON);
            endcase
        end
        if (quoted) begin
            send_byte(CH_QUOTE);
            repeat (vlen) begin
                case ($urandom_range(19))
                    0: begin
                        send_byte(CH_BACKSLASH);
                        send_byte(CH_QUOTE);
                        last_bs = 1'b0;
                    end
                    1: begin
                        send_byte(CH_BACKSLASH);
                        last_bs = 1'b1;
                    end
                    default: begin
                        send_byte(pick_char(CH_QUOTE, CH_RBRACE, CH_BACKSLASH, CH_QUOTE));
                        last_bs = 1'b0;
                    end
                endcase
            end
            // Keep a trailing backslash from escaping the closing quote.
            if (last_bs) send_byte("v");
            if ($urandom_range(6) == 0) begin
                send_byte(CH_RBRACE);
            end else begin
                send_byte(CH_QUOTE);
                send_byte(pick_char(CH_NUL, CH_NUL, CH_NUL, CH_NUL));
            end
        end else begin
            for (int i = 0; i < vlen; i++) begin
                ch = pick_char(CH_SPACE, CH_NEWLINE, CH_RBRACE, CH_COMMA);
                if (i == 0 && (ch == CH_COLON || ch == CH_QUOTE)) ch = "v";
                send_byte(ch);
            end
            // An empty bare value needs a terminator the separator skip does not eat.
            case ($urandom_range(3))
                0:       send_byte(vlen == 0 ? CH_NEWLINE : CH_SPACE);
                1:       send_byte(CH_NEWLINE);
                2:       send_byte(CH_RBRACE);
                default: send_byte(vlen == 0 ? CH_RBRACE : CH_COMMA);
            endcase
        end
    endtask

    // Capitals fold, the codes just outside the capital range and high bytes do not.
    task automatic test_key_case_folding;
        gap_pct   = 0;
        stall_pct = 0;
        send_byte(CH_QUOTE);
        send_byte("A");
        send_byte("Z");
        send_byte(CH_UPPER_LO);
        send_byte(CH_UPPER_HI);
        send_byte(8'hFF);
        send_byte(8'h01);
        send_byte(CH_QUOTE);
        send_byte(CH_COLON);
        send_byte("7");
        send_byte(CH_COMMA);
    endtask

    // Escaped quote kept, raw backslash kept, the byte after the close skipped.
    task automatic test_quoted_values;
        send_byte(CH_QUOTE);
        send_byte("k");
        send_byte(CH_QUOTE);
        send_byte(CH_SPACE);
        send_byte(CH_COLON);
        send_byte(CH_QUOTE);
        send_byte(CH_BACKSLASH);
        send_byte(CH_QUOTE);
        send_byte("x");
        send_byte(CH_QUOTE);
        send_byte(CH_QUOTE);
    endtask

    // An empty key produces no pair-end marker.
    task automatic test_empty_key;
        send_byte(CH_QUOTE);
        send_byte(CH_QUOTE);
        send_byte(CH_RBRACE);
    endtask

    // Overlong key and values: the excess is dropped, the fields still end right.
    task automatic test_length_caps;
        gap_pct   = 32;
        stall_pct = 32;
        send_byte(CH_QUOTE);
        repeat (KEY_MAX + 3) send_byte(pick_char(CH_QUOTE, CH_QUOTE, CH_QUOTE, CH_QUOTE));
        send_byte(CH_QUOTE);
        send_byte(CH_COLON);
        send_byte(CH_QUOTE);
        repeat (VALUE_MAX + 1) begin
            send_byte(pick_char(CH_QUOTE, CH_RBRACE, CH_BACKSLASH, CH_QUOTE));
        end
        // Backslash past the cap is dropped yet still escapes the next quote.
        send_byte(CH_BACKSLASH);
        send_byte(CH_QUOTE);
        send_byte("z");
        send_byte(CH_QUOTE);
        send_byte(CH_COMMA);
        send_pair(2, VALUE_MAX + 4, 1'b0);
    endtask

    // Mostly well-formed pairs, with bursts of noise between them.
    task automatic test_random_documents(input int sender_idle, input int receiver_stall,
                                         input int n_bytes);
        int stop_at;
        gap_pct   = sender_idle;
        stall_pct = receiver_stall;
        stop_at   = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            if ($urandom_range(99) < 85) begin
                send_pair(random_field_len(), random_field_len(), 1'($urandom_range(1)));
            end else begin
                repeat ($urandom_range(6, 1)) send_byte(pick_char(CH_NUL, CH_NUL, CH_NUL,
                                                                  CH_NUL));
            end
        end
    endtask

    // Close an open pair by NUL or by a final-flagged char, then check silence.
    task automatic test_halt;
        gap_pct   = 32;
        stall_pct = 62;
        // Bring the parser back outside any pair first.
        while (parse_phase != PH_OUTSIDE) begin
            send_byte(parse_phase == PH_KEY ? CH_QUOTE : CH_RBRACE);
        end
        send_byte(CH_QUOTE);
        send_byte("h");
        send_byte(CH_QUOTE);
        send_byte(CH_COLON);
        if ($urandom_range(1)) send_byte(CH_QUOTE);
        send_byte("w");
        if ($urandom_range(1)) send_byte(CH_NUL, 1'($urandom_range(1)));
        else send_byte("v", 1'b1);
        send_byte(CH_NUL);
        repeat (24) send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
    endtask

    // Drop valid, wait for every awaited result, then watch for strays.
    task automatic wait_for_drain;
        int waited;
        in_valid <= 1'b0;
        waited = 0;
        while (awaited_chars.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        repeat (32) @(posedge clk);
        if (awaited_chars.size() != 0) begin
            flag_error($sformatf("missing %0d results at end of run", awaited_chars.size()));
        end
    endtask

    // Check each accepted result against the oldest expectation; stall at random.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (awaited_chars.size() == 0) begin
                    flag_error($sformatf("unexpected result: char %h kind %0d quoted %b end %b",
                                         out_item.out_char, out_item.char_kind,
                                         out_item.value_quoted, out_item.run_end));
                end else begin
                    expected_head = awaited_chars.pop_front();
                    if (out_item.out_char !== expected_head.out_char ||
                        out_item.char_kind !== expected_head.char_kind ||
                        out_item.value_quoted !== expected_head.value_quoted ||
                        out_item.run_end !== expected_head.run_end) begin
                        flag_error($sformatf(
                            "mismatch: want char %h kind %0d quoted %b end %b, got %h %0d %b %b",
                            expected_head.out_char, expected_head.char_kind,
                            expected_head.value_quoted, expected_head.run_end,
                            out_item.out_char, out_item.char_kind,
                            out_item.value_quoted, out_item.run_end));
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Hold reset, then run the tests in turn over one continuous document.
    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        test_key_case_folding();
        test_quoted_values();
        test_empty_key();
        test_length_caps();
        test_random_documents(0, 0, 220);
        test_random_documents(62, 0, 220);
        test_random_documents(0, 62, 220);
        test_random_documents(32, 32, 220);
        test_halt();
        wait_for_drain();
        if (error_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/fjpe_pkg.sv
hw/rtl/fjpe_core.sv
hw/rtl/fjpe_out_queue.sv
hw/rtl/flat_json_pair_extractor_unit.sv
hw/rtl/fjpe_checker.sv
tb/testbench.sv
